// ----- design/kdc_pkg.sv -----
`timescale 1ns / 1ps
package kdc_pkg;

  // Widest slot index for the largest supported table
  localparam int unsigned SlotW       = 10;
  localparam int unsigned DefCapacity = 128;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_MERGED  = 3'd0,
    ACT_KEPT    = 3'd1,
    ACT_APPEND  = 3'd2,
    ACT_EVICT   = 3'd3,
    ACT_DROP    = 3'd4,
    ACT_READ_OK = 3'd5,
    ACT_READ_OR = 3'd6,
    ACT_CLEARED = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0]        key_a;
    logic [15:0]        key_b;
    logic signed [31:0] depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic [7:0]         type_a;
    logic [7:0]         type_b;
  } entry_t;

  // Travels down the chain, one cell per cycle
  typedef struct packed {
    logic               found;
    logic [SlotW-1:0]   slot;
    entry_t             hit;
    logic signed [31:0] min_depth;
    logic [SlotW-1:0]   min_slot;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    entry_t           data;
  } write_t;

endpackage

// ----- design/kdc_if.sv -----
`timescale 1ns / 1ps
interface kdc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        key_a;
  logic [15:0]        key_b;
  logic signed [31:0] depth;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic [7:0]         type_a;
  logic [7:0]         type_b;
  logic [6:0]         read_index;

  modport source (output valid, command, key_a, key_b, depth, point_x, point_y,
                  normal_x, normal_y, type_a, type_b, read_index, input ready);
  modport sink (input valid, command, key_a, key_b, depth, point_x, point_y,
                normal_x, normal_y, type_a, type_b, read_index, output ready);
endinterface

interface kdc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [6:0]         slot;
  logic [7:0]         entry_total;
  logic               capped;
  logic [15:0]        out_key_a;
  logic [15:0]        out_key_b;
  logic signed [31:0] out_depth;
  logic signed [31:0] out_point_x;
  logic signed [31:0] out_point_y;
  logic signed [31:0] out_normal_x;
  logic signed [31:0] out_normal_y;
  logic [15:0]        out_types;

  modport source (output valid, action, slot, entry_total, capped, out_key_a,
                  out_key_b, out_depth, out_point_x, out_point_y, out_normal_x,
                  out_normal_y, out_types, input ready);
  modport sink (input valid, action, slot, entry_total, capped, out_key_a,
                out_key_b, out_depth, out_point_x, out_point_y, out_normal_x,
                out_normal_y, out_types, output ready);
endinterface

// ----- design/kdc_cell.sv -----
`timescale 1ns / 1ps
module kdc_cell import kdc_pkg::*; #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      command_i,
  input  logic [15:0]     key_a_i,
  input  logic [15:0]     key_b_i,
  input  logic [6:0]      read_index_i,
  input  logic [CntW-1:0] count_i,
  input  write_t          wr_i,
  input  token_t          tok_i,
  output token_t          tok_o
);

  entry_t entry_q;
  token_t tok_d, tok_q;
  logic   here;

  assign here = (32'(count_i) > Index);

  // Store the entry when the write names this slot
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (32'(wr_i.slot) == Index)) begin
      entry_q <= wr_i.data;
    end
  end

  // Merge this cell into the passing token
  always_comb begin
    tok_d = tok_i;
    if (Index == 0) begin
      tok_d.min_depth = entry_q.depth;
      tok_d.min_slot  = '0;
    end else if (entry_q.depth < tok_i.min_depth) begin
      tok_d.min_depth = entry_q.depth;
      tok_d.min_slot  = SlotW'(Index);
    end
    if (here && !tok_i.found) begin
      if (command_i == CMD_INSERT) begin
        if (entry_q.key_a == key_a_i && entry_q.key_b == key_b_i) begin
          tok_d.found = 1'b1;
          tok_d.slot  = SlotW'(Index);
          tok_d.hit   = entry_q;
        end
      end else if (32'(read_index_i) == Index) begin
        tok_d.found = 1'b1;
        tok_d.slot  = SlotW'(Index);
        tok_d.hit   = entry_q;
      end
    end
  end

  // Hand the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- design/keyed_deepest_contact_table.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_i    | in  | command, key_a, key_b, depth, point/normal x y, type_a/b, read_index
// out_o   | out | action, slot, entry_total, capped, read entry fields
//
// Insert and read pass the scan, decide and output states: a token walks the row of cells,
// one cell per cycle, gathering key match, read hit and shallowest entry.
// Clear goes straight to the output state; command 3 is absorbed without a result.
// Reset empties the table; entries hold no reset value.
// A stalled result holds the block; no new item is taken until it leaves.
module keyed_deepest_contact_table import kdc_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input logic clk_i,
  input logic rst_ni,
  kdc_in_if.sink    in_i,
  kdc_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d, scan_q, scan_d;
  logic [15:0]     tries_q, tries_d;
  logic            cap_q, cap_d;
  logic [1:0]      cmd_q;
  entry_t          item_q;
  logic [6:0]      ridx_q;
  write_t          wr;
  token_t          tok [CAPACITY+1];
  token_t          last;

  logic [2:0]  act_q, act_d;
  logic [6:0]  slot_q, slot_d;
  entry_t      rd_q, rd_d;
  logic        accept;

  assign accept = in_i.valid && in_i.ready;
  assign tok[0] = '0;
  assign last   = tok[CAPACITY];

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    kdc_cell #(.Index(g), .CntW(CntW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .command_i   (cmd_q),
      .key_a_i     (item_q.key_a),
      .key_b_i     (item_q.key_b),
      .read_index_i(ridx_q),
      .count_i     (count_q),
      .wr_i        (wr),
      .tok_i       (tok[g]),
      .tok_o       (tok[g+1])
    );
  end

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.command;
      ridx_q <= in_i.read_index;
      item_q <= '{in_i.key_a, in_i.key_b, in_i.depth, in_i.point_x, in_i.point_y,
                  in_i.normal_x, in_i.normal_y, in_i.type_a, in_i.type_b};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      tries_q <= '0;
      cap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      tries_q <= tries_d;
      cap_q   <= cap_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    slot_q <= slot_d;
    rd_q   <= rd_d;
  end

  // Sequence and decide
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    scan_d  = scan_q;
    tries_d = tries_q;
    cap_d   = cap_q;
    act_d   = act_q;
    slot_d  = slot_q;
    rd_d    = rd_q;
    wr      = '{en: 1'b0, slot: '0, data: item_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_d = '0;
          case (in_i.command)
            CMD_INSERT, CMD_READ: state_d = ST_SCAN;
            CMD_CLEAR: begin
              count_d = '0;
              tries_d = '0;
              cap_d   = 1'b0;
              act_d   = ACT_CLEARED;
              slot_d  = '0;
              rd_d    = '0;
              state_d = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (32'(scan_q) == CAPACITY - 1) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        rd_d    = '0;
        slot_d  = '0;
        state_d = ST_OUT;
        if (cmd_q == CMD_INSERT) begin
          if (tries_q != 16'hFFFF) begin
            tries_d = tries_q + 1'b1;
          end
          if (32'(tries_d) > CAPACITY) begin
            cap_d = 1'b1;
          end
          if (last.found) begin
            slot_d = last.slot[6:0];
            if (item_q.depth > last.hit.depth) begin
              wr.en   = 1'b1;
              wr.slot = last.slot;
              act_d   = ACT_MERGED;
            end else begin
              act_d = ACT_KEPT;
            end
          end else if (32'(count_q) < CAPACITY) begin
            wr.en   = 1'b1;
            wr.slot = SlotW'(count_q);
            slot_d  = 7'(count_q);
            count_d = count_q + 1'b1;
            act_d   = ACT_APPEND;
          end else begin
            cap_d = 1'b1;
            if (item_q.depth > last.min_depth) begin
              wr.en   = 1'b1;
              wr.slot = last.min_slot;
              slot_d  = last.min_slot[6:0];
              act_d   = ACT_EVICT;
            end else begin
              act_d = ACT_DROP;
            end
          end
        end else if (last.found) begin
          act_d  = ACT_READ_OK;
          slot_d = ridx_q;
          rd_d   = last.hit;
        end else begin
          act_d = ACT_READ_OR;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.action       = act_q;
  assign out_o.slot         = slot_q;
  assign out_o.entry_total  = 8'(count_q);
  assign out_o.capped       = cap_q;
  assign out_o.out_key_a    = rd_q.key_a;
  assign out_o.out_key_b    = rd_q.key_b;
  assign out_o.out_depth    = rd_q.depth;
  assign out_o.out_point_x  = rd_q.point_x;
  assign out_o.out_point_y  = rd_q.point_y;
  assign out_o.out_normal_x = rd_q.normal_x;
  assign out_o.out_normal_y = rd_q.normal_y;
  assign out_o.out_types    = {rd_q.type_a, rd_q.type_b};

endmodule

// ----- tb/sv/keyed_deepest_contact_table_tb.sv -----
`timescale 1ns / 1ps
module keyed_deepest_contact_table_tb;
  import kdc_pkg::*;

  localparam int unsigned Cap        = DefCapacity;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItems  = 800;

  typedef struct {
    logic [1:0]  command;
    entry_t      ent;
    logic [6:0]  read_index;
  } contact_item_t;

  typedef struct {
    act_e        action;
    logic [6:0]  slot;
    logic [7:0]  entry_total;
    logic        capped;
    entry_t      ent;
  } table_result_t;

  // Mirror of the contact table; predicts one result per command other than command 3
  class contact_scoreboard;
    entry_t          rows [Cap];
    int unsigned     count;
    int unsigned     attempts;
    bit              overflow;
    table_result_t   pending [$];
    int unsigned     errors;

    function new();
      count = 0;
      attempts = 0;
      overflow = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Work out the outcome of one accepted item and queue it, unless the command is unused
    function void note_item(contact_item_t it);
      table_result_t r;
      int unsigned   low;
      bit            found;
      r.action = ACT_MERGED;
      r.slot = '0;
      r.ent = '0;
      found = 0;
      if (it.command == CMD_UNUSED) return;
      case (it.command)
        CMD_INSERT: begin
          if (attempts < 16'hFFFF) attempts++;
          if (attempts > Cap) overflow = 1;
          for (int i = 0; i < count; i++) begin
            if (!found && rows[i].key_a == it.ent.key_a && rows[i].key_b == it.ent.key_b) begin
              found = 1;
              r.slot = 7'(i);
              if (it.ent.depth > rows[i].depth) begin
                rows[i] = it.ent;
                r.action = ACT_MERGED;
              end else begin
                r.action = ACT_KEPT;
              end
            end
          end
          if (!found) begin
            if (count < Cap) begin
              rows[count] = it.ent;
              r.slot = 7'(count);
              count++;
              r.action = ACT_APPEND;
            end else begin
              overflow = 1;
              low = 0;
              for (int i = 1; i < Cap; i++)
                if (rows[i].depth < rows[low].depth) low = i;
              if (it.ent.depth > rows[low].depth) begin
                rows[low] = it.ent;
                r.slot = 7'(low);
                r.action = ACT_EVICT;
              end else begin
                r.action = ACT_DROP;
              end
            end
          end
        end
        CMD_READ: begin
          if (it.read_index < count) begin
            r.action = ACT_READ_OK;
            r.slot = it.read_index;
            r.ent = rows[it.read_index];
          end else begin
            r.action = ACT_READ_OR;
          end
        end
        default: begin
          count = 0;
          attempts = 0;
          overflow = 0;
          r.action = ACT_CLEARED;
        end
      endcase
      r.entry_total = 8'(count);
      r.capped = overflow;
      pending.push_back(r);
    endfunction

    // Compare one accepted result with the oldest outcome
    task check_result(table_result_t got);
      table_result_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.action !== e.action)
        report($sformatf("action %0d, wanted %0d", got.action, e.action));
      if (got.slot !== e.slot)
        report($sformatf("slot %0d, wanted %0d", got.slot, e.slot));
      if (got.entry_total !== e.entry_total)
        report($sformatf("entry_total %0d, wanted %0d", got.entry_total, e.entry_total));
      if (got.capped !== e.capped)
        report($sformatf("capped %0b, wanted %0b", got.capped, e.capped));
      if (got.ent !== e.ent)
        report($sformatf("read entry %h, wanted %h", got.ent, e.ent));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  kdc_in_if  in_if ();
  kdc_out_if out_if ();

  keyed_deepest_contact_table #(.CAPACITY(Cap)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  contact_scoreboard sb = new();
  int unsigned cycles = 0;
  bit          hold_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample each accepted result
  always @(posedge clk_i) begin
    table_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.action      = act_e'(out_if.action);
      got.slot        = out_if.slot;
      got.entry_total = out_if.entry_total;
      got.capped      = out_if.capped;
      got.ent = '{out_if.out_key_a, out_if.out_key_b, out_if.out_depth,
                  out_if.out_point_x, out_if.out_point_y, out_if.out_normal_x,
                  out_if.out_normal_y, out_if.out_types[15:8], out_if.out_types[7:0]};
      sb.check_result(got);
    end
  end

  // Receiver: stall pattern, free-running stretches, one long hold-off
  initial begin
    int unsigned stretch;
    int unsigned mode;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stretch = $urandom_range(20, 400);
      mode = $urandom_range(0, 2);
      if (!hold_done && cycles > 15000) begin
        hold_done = 1;
        out_if.ready = 1'b0;
        repeat (3000) @(negedge clk_i);
      end
      repeat (stretch) begin
        @(negedge clk_i);
        case (mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = ($urandom_range(0, 3) != 0);
          default: out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until taken
  task send_item(contact_item_t it);
    in_if.valid      = 1'b1;
    in_if.command    = it.command;
    in_if.key_a      = it.ent.key_a;
    in_if.key_b      = it.ent.key_b;
    in_if.depth      = it.ent.depth;
    in_if.point_x    = it.ent.point_x;
    in_if.point_y    = it.ent.point_y;
    in_if.normal_x   = it.ent.normal_x;
    in_if.normal_y   = it.ent.normal_y;
    in_if.type_a     = it.ent.type_a;
    in_if.type_b     = it.ent.type_b;
    in_if.read_index = it.read_index;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task idle_for(int unsigned n);
    in_if.valid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic contact_item_t make_insert(logic [15:0] ka, logic [15:0] kb,
                                                logic signed [31:0] d);
    contact_item_t it;
    it.command = CMD_INSERT;
    it.ent = '{ka, kb, d, $urandom, $urandom, $urandom, $urandom,
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    it.read_index = 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic contact_item_t make_other(logic [1:0] cmd, logic [6:0] idx);
    contact_item_t it;
    it = make_insert(16'($urandom), 16'($urandom), $urandom);
    it.command = cmd;
    it.read_index = idx;
    return it;
  endfunction

  // Mostly keys from a pool a little larger than the table, so it fills
  function automatic contact_item_t make_random();
    contact_item_t it;
    int unsigned   pick;
    int unsigned   k;
    logic signed [31:0] d;
    pick = $urandom_range(0, 199);
    if (pick < 2) return make_other(CMD_CLEAR, 7'($urandom));
    if (pick < 8) return make_other(CMD_UNUSED, 7'($urandom));
    if (pick < 60) begin
      if ($urandom_range(0, 3) == 0) return make_other(CMD_READ, 7'($urandom));
      return make_other(CMD_READ,
                        7'($urandom_range(0, sb.count == 0 ? 0 : sb.count - 1)));
    end
    k = $urandom_range(0, 169);
    d = $urandom;
    if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    if ($urandom_range(0, 4) == 0) return make_insert(16'($urandom), 16'($urandom), d);
    return make_insert(16'(k * 385), ~k[15:0], d);
  endfunction

  initial begin
    contact_item_t it;
    int unsigned   burst;
    in_if.valid = 1'b0;
    in_if.command = '0;
    in_if.key_a = '0;
    in_if.key_b = '0;
    in_if.depth = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.normal_x = '0;
    in_if.normal_y = '0;
    in_if.type_a = '0;
    in_if.type_b = '0;
    in_if.read_index = '0;
    burst = 0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty reads, extremes, merge and keep, unused command, clear
    send_item(make_other(CMD_READ, 7'd0));
    send_item(make_other(CMD_READ, 7'd127));
    it = make_insert(16'hFFFF, 16'h0000, 32'sh80000000);
    it.ent.point_x = 32'sh7FFFFFFF; it.ent.point_y = 32'sh80000000;
    it.ent.normal_x = 32'sh80000000; it.ent.normal_y = 32'sh7FFFFFFF;
    it.ent.type_a = 8'hFF; it.ent.type_b = 8'h00;
    send_item(it);
    send_item(make_insert(16'h0000, 16'hFFFF, 32'sh7FFFFFFF));
    send_item(make_insert(16'hFFFF, 16'h0000, 32'sh80000000));
    send_item(make_insert(16'hFFFF, 16'h0000, 32'sh00010000));
    send_item(make_insert(16'h0000, 16'hFFFF, 32'sh7FFFFFFF));
    send_item(make_other(CMD_UNUSED, 7'd0));
    send_item(make_other(CMD_READ, 7'd0));
    send_item(make_other(CMD_READ, 7'd1));
    send_item(make_other(CMD_READ, 7'd2));
    send_item(make_other(CMD_CLEAR, 7'd0));
    send_item(make_other(CMD_READ, 7'd0));

    // Random, in bursts with gaps; drain fully once midway
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) begin
        in_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 25);
        if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 40));
      end
      burst--;
      send_item(make_random());
    end
    in_if.valid = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4 * Cap + 40) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- keyed_deepest_contact_table.f -----
design/kdc_pkg.sv
design/kdc_if.sv
design/kdc_cell.sv
design/keyed_deepest_contact_table.sv
tb/sv/keyed_deepest_contact_table_tb.sv
